>>> rtl/jsu_pkg.sv
package jsu_pkg;

	localparam int UNIT_W = 16;

	localparam logic [UNIT_W-1:0] CH_BSL   = 16'h005C;
	localparam logic [UNIT_W-1:0] CH_N     = 16'h006E;
	localparam logic [UNIT_W-1:0] CH_T     = 16'h0074;
	localparam logic [UNIT_W-1:0] CH_QUOTE = 16'h0022;
	localparam logic [UNIT_W-1:0] CH_SLASH = 16'h002F;
	localparam logic [UNIT_W-1:0] CH_U     = 16'h0075;
	localparam logic [UNIT_W-1:0] CH_LF    = 16'h000A;
	localparam logic [UNIT_W-1:0] CH_TAB   = 16'h0009;

endpackage

>>> rtl/jsu_in_if.sv
interface jsu_in_if import jsu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [UNIT_W-1:0] code_unit;
	logic              end_of_string;

	modport source (output valid, output code_unit, output end_of_string, input ready);
	modport sink   (input valid, input code_unit, input end_of_string, output ready);
endinterface

>>> rtl/jsu_out_if.sv
interface jsu_out_if import jsu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [UNIT_W-1:0] out_unit;
	logic              unit_valid;
	logic              last;

	modport source (output valid, output out_unit, output unit_valid, output last, input ready);
	modport sink   (input valid, input out_unit, input unit_valid, input last, output ready);
endinterface

>>> rtl/json_string_unescape_top.sv
// JSON string unescaper, one UTF-16 code unit per word.
// The escaped channel takes one code unit per word, with end_of_string set on
// the final unit of a string. The unescaped channel delivers the decoded text,
// one code unit per word, with last set on the final word of the string. An
// end word that yields no character gives one word with unit_valid low.
// A word is taken into an input register; the escape logic resolves it there
// and, once the result register is free, loads that register with up to three
// code units, from which the output is offered. Throughput is one input word
// per cycle as long as each word yields at most one result and the receiver is
// ready. A word that yields several results holds the result register until
// all are taken, one code unit per cycle while the receiver is ready; words
// that yield nothing (a backslash, collected hex digits) pass without using it.
// The input stays ready while a result waits, until the input register itself
// is blocked behind a full result register; a stalled receiver then holds the
// input back without losing or repeating any word.
// Reset clears the escape mode, the hex count and both registers; the hex
// buffer holds no meaning until units are collected into it.
module json_string_unescape_top import jsu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	jsu_in_if.sink    escaped,
	jsu_out_if.source unescaped
);

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_ESC    = 2'd1,
		MODE_HEX    = 2'd2
	} mode_t;

	typedef struct packed {
		logic [2:0][UNIT_W-1:0] unit;
		logic [1:0]             n;
	} res_list_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_digit_t;

	function automatic res_list_t add_unit(res_list_t l, logic [UNIT_W-1:0] v);
		res_list_t r;
		r = l;
		if (l.n != 2'd3) begin
			r.unit[l.n] = v;
			r.n = l.n + 2'd1;
		end
		return r;
	endfunction

	function automatic res_list_t add_escaped(res_list_t l, logic [UNIT_W-1:0] u);
		res_list_t r;
		r = l;
		if (u == CH_N) begin
			r = add_unit(r, CH_LF);
		end else if (u == CH_T) begin
			r = add_unit(r, CH_TAB);
		end else if (u == CH_QUOTE || u == CH_BSL || u == CH_SLASH) begin
			r = add_unit(r, u);
		end else begin
			r = add_unit(r, CH_BSL);
			r = add_unit(r, u);
		end
		return r;
	endfunction

	function automatic hex_digit_t hex_digit(logic [UNIT_W-1:0] c);
		hex_digit_t d;
		d.ok = 1'b1;
		d.val = c[3:0];
		if (c >= 16'h0030 && c <= 16'h0039) begin
			d.val = c[3:0];
		end else if ((c >= 16'h0061 && c <= 16'h0066) || (c >= 16'h0041 && c <= 16'h0046)) begin
			d.val = c[3:0] + 4'd9;
		end else begin
			d.ok = 1'b0;
		end
		return d;
	endfunction

	mode_t                  mode_q, mode_d;
	logic [1:0]             hex_count_q, hex_count_d;
	logic [2:0][UNIT_W-1:0] hex_buf_q;
	logic                   buf_we;

	logic                   v_s1;
	logic [UNIT_W-1:0]      unit_s1;
	logic                   end_s1;

	logic                   busy_q;
	logic [2:0][UNIT_W-1:0] res_unit_q;
	logic [1:0]             res_cnt_q;
	logic [1:0]             res_idx_q;
	logic                   res_uv_q;
	logic                   res_end_q;

	res_list_t              lst;
	logic [3:0][UNIT_W-1:0] hex_seq;
	logic [UNIT_W-1:0]      hex_acc;
	logic                   hex_any;
	logic                   hex_run;
	hex_digit_t             dig;

	logic in_fire, out_fire, final_take, res_free, adv, res_load;

	always_comb begin
		hex_seq = {unit_s1, hex_buf_q[2], hex_buf_q[1], hex_buf_q[0]};
		hex_acc = '0;
		hex_any = 1'b0;
		hex_run = 1'b1;
		dig = '0;
		for (int k = 0; k < 4; k++) begin
			dig = hex_digit(hex_seq[k]);
			if (hex_run && dig.ok) begin
				hex_acc = {hex_acc[UNIT_W-5:0], dig.val};
				hex_any = 1'b1;
			end else begin
				hex_run = 1'b0;
			end
		end
	end

	always_comb begin
		lst = '0;
		mode_d = mode_q;
		hex_count_d = hex_count_q;
		buf_we = 1'b0;
		unique case (mode_q)
			MODE_ESC: begin
				mode_d = MODE_NORMAL;
				if (unit_s1 == CH_U) begin
					if (!end_s1) begin
						mode_d = MODE_HEX;
						hex_count_d = 2'd0;
					end
				end else begin
					lst = add_escaped(lst, unit_s1);
				end
			end
			MODE_HEX: begin
				if (hex_count_q == 2'd3) begin
					if (hex_any) begin
						lst = add_unit(lst, hex_acc);
					end
					mode_d = MODE_NORMAL;
					hex_count_d = 2'd0;
				end else begin
					buf_we = 1'b1;
					hex_count_d = hex_count_q + 2'd1;
					if (end_s1) begin
						case (hex_count_q)
							2'd0: lst = add_unit(lst, unit_s1);
							2'd1: begin
								if (hex_buf_q[0] == CH_BSL) begin
									if (unit_s1 != CH_U) begin
										lst = add_escaped(lst, unit_s1);
									end
								end else begin
									lst = add_unit(lst, hex_buf_q[0]);
									lst = add_unit(lst, unit_s1);
								end
							end
							2'd2: begin
								if (hex_buf_q[0] == CH_BSL) begin
									if (hex_buf_q[1] != CH_U) begin
										lst = add_escaped(lst, hex_buf_q[1]);
									end
									lst = add_unit(lst, unit_s1);
								end else begin
									lst = add_unit(lst, hex_buf_q[0]);
									if (hex_buf_q[1] == CH_BSL) begin
										if (unit_s1 != CH_U) begin
											lst = add_escaped(lst, unit_s1);
										end
									end else begin
										lst = add_unit(lst, hex_buf_q[1]);
										lst = add_unit(lst, unit_s1);
									end
								end
							end
							default: ;
						endcase
					end
				end
			end
			default: begin
				if (unit_s1 == CH_BSL && !end_s1) begin
					mode_d = MODE_ESC;
				end else begin
					lst = add_unit(lst, unit_s1);
				end
			end
		endcase
		if (end_s1) begin
			mode_d = MODE_NORMAL;
			hex_count_d = 2'd0;
		end
	end

	assign out_fire   = busy_q && unescaped.ready;
	assign final_take = out_fire && (res_idx_q == res_cnt_q - 2'd1);
	assign res_free   = !busy_q || final_take;
	assign adv        = v_s1 && (((lst.n == 2'd0) && !end_s1) || res_free);
	assign res_load   = adv && ((lst.n != 2'd0) || end_s1);
	assign escaped.ready = !v_s1 || adv;
	assign in_fire    = escaped.valid && escaped.ready;

	assign unescaped.valid      = busy_q;
	assign unescaped.out_unit   = res_unit_q[res_idx_q];
	assign unescaped.unit_valid = res_uv_q;
	assign unescaped.last       = res_end_q && (res_idx_q == res_cnt_q - 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			hex_count_q <= 2'd0;
			hex_buf_q <= '0;
			v_s1 <= 1'b0;
			unit_s1 <= '0;
			end_s1 <= 1'b0;
			busy_q <= 1'b0;
			res_unit_q <= '0;
			res_cnt_q <= 2'd1;
			res_idx_q <= 2'd0;
			res_uv_q <= 1'b0;
			res_end_q <= 1'b0;
		end else begin
			if (in_fire) begin
				v_s1 <= 1'b1;
				unit_s1 <= escaped.code_unit;
				end_s1 <= escaped.end_of_string;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				mode_q <= mode_d;
				hex_count_q <= hex_count_d;
				if (buf_we) begin
					hex_buf_q[hex_count_q] <= unit_s1;
				end
			end
			if (res_load) begin
				busy_q <= 1'b1;
				res_unit_q <= lst.unit;
				res_cnt_q <= (lst.n == 2'd0) ? 2'd1 : lst.n;
				res_idx_q <= 2'd0;
				res_uv_q <= (lst.n != 2'd0);
				res_end_q <= end_s1;
			end else if (final_take) begin
				busy_q <= 1'b0;
			end else if (out_fire) begin
				res_idx_q <= res_idx_q + 2'd1;
			end
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (res_idx_q < res_cnt_q) && (res_cnt_q != 2'd0))
		else $error("result index beyond result count");

	a_marker_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(unescaped.valid && !unescaped.unit_valid) |-> unescaped.last)
		else $error("empty marker not flagged last");

	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && end_s1) |-> res_load)
		else $error("end of string retired without a result");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |=> (v_s1 && $stable(unit_s1) && $stable(end_s1)))
		else $error("blocked input word lost");

	a_end_resets_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && end_s1) |=> (mode_q == MODE_NORMAL && hex_count_q == 2'd0))
		else $error("mode not cleared at end of string");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import jsu_pkg::*;

	localparam logic [UNIT_W-1:0] DIG_0 = 16'h0030;
	localparam logic [UNIT_W-1:0] DIG_9 = 16'h0039;
	localparam logic [UNIT_W-1:0] LOW_A = 16'h0061;
	localparam logic [UNIT_W-1:0] LOW_F = 16'h0066;
	localparam logic [UNIT_W-1:0] UP_A  = 16'h0041;
	localparam logic [UNIT_W-1:0] UP_F  = 16'h0046;
	localparam int LONG_HOLD = 80;
	localparam int DRAIN_CYCLES = 20;

	typedef enum logic [1:0] {MODE_TEXT, MODE_ESCAPE, MODE_HEX} esc_mode_t;

	typedef struct packed {
		logic [UNIT_W-1:0] text_unit;
		logic              unit_valid;
		logic              last;
	} text_word_t;

	class unescape_scoreboard;
		esc_mode_t         esc_mode = MODE_TEXT;
		logic [UNIT_W-1:0] hex_buf [4];
		logic [2:0]        hex_cnt = '0;
		text_word_t        step_q [$];
		text_word_t        expected_q [$];
		int                errors = 0;

		function void emit(logic [UNIT_W-1:0] u);
			text_word_t w;
			w.text_unit = u;
			w.unit_valid = 1'b1;
			w.last = 1'b0;
			step_q.insert(step_q.size(), w);
		endfunction

		function void emit_escaped(logic [UNIT_W-1:0] u);
			case (u)
				CH_N: emit(CH_LF);
				CH_T: emit(CH_TAB);
				CH_QUOTE, CH_BSL, CH_SLASH: emit(u);
				default: begin
					emit(CH_BSL);
					emit(u);
				end
			endcase
		endfunction

		function void note_word(logic [UNIT_W-1:0] u, logic eos);
			logic [UNIT_W-1:0] val;
			logic [UNIT_W-1:0] c;
			logic [3:0]        d;
			bit                any;
			bit                stop;
			int                j;
			text_word_t        w;
			step_q.delete();
			case (esc_mode)
				MODE_ESCAPE: begin
					esc_mode = MODE_TEXT;
					if (u == CH_U) begin
						if (!eos) begin
							esc_mode = MODE_HEX;
							hex_cnt = '0;
						end
					end else
						emit_escaped(u);
				end
				MODE_HEX: begin
					hex_buf[hex_cnt[1:0]] = u;
					hex_cnt = hex_cnt + 3'd1;
					if (hex_cnt >= 3'd4) begin
						val = '0;
						any = 0;
						stop = 0;
						for (j = 0; j < 4; j++) begin
							c = hex_buf[j];
							if (!stop) begin
								if (c >= DIG_0 && c <= DIG_9)
									d = c[3:0];
								else if ((c >= LOW_A && c <= LOW_F) || (c >= UP_A && c <= UP_F))
									d = c[3:0] + 4'd9;
								else
									stop = 1;
								if (!stop) begin
									val = {val[11:0], d};
									any = 1;
								end
							end
						end
						if (any)
							emit(val);
						esc_mode = MODE_TEXT;
						hex_cnt = '0;
					end else if (eos) begin
						// The short group is decoded again as plain text.
						for (j = 0; j < hex_cnt; j++) begin
							c = hex_buf[j];
							if (c == CH_BSL && j + 1 < hex_cnt) begin
								j++;
								c = hex_buf[j];
								if (c != CH_U)
									emit_escaped(c);
							end else
								emit(c);
						end
					end
				end
				default: begin
					if (u == CH_BSL && !eos)
						esc_mode = MODE_ESCAPE;
					else
						emit(u);
				end
			endcase
			if (eos) begin
				if (step_q.size() == 0) begin
					w.text_unit = '0;
					w.unit_valid = 1'b0;
					w.last = 1'b1;
					step_q.insert(step_q.size(), w);
				end else
					step_q[step_q.size() - 1].last = 1'b1;
				esc_mode = MODE_TEXT;
				hex_cnt = '0;
			end
			foreach (step_q[i])
				expected_q.insert(expected_q.size(), step_q[i]);
		endfunction

		function void check_word(logic [UNIT_W-1:0] u, logic v, logic l);
			text_word_t w;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word: expected none, got unit %h valid %b last %b",
					$time, u, v, l);
			end else begin
				w = expected_q.pop_front();
				if (w.text_unit !== u || w.unit_valid !== v || w.last !== l) begin
					errors++;
					$display("%0t: mismatch: expected unit %h valid %b last %b,",
						$time, w.text_unit, w.unit_valid, w.last,
						" got unit %h valid %b last %b", u, v, l);
				end
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   tx_idle;
	bit   rx_idle;
	bit   long_hold;
	int   words_sent = 0;
	logic [UNIT_W-1:0] str_q [$];

	unescape_scoreboard sb = new();

	jsu_in_if  escaped_ch ();
	jsu_out_if unescaped_ch ();

	json_string_unescape_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.escaped   (escaped_ch),
		.unescaped (unescaped_ch)
	);

	always #6 clk = ~clk;

	function automatic void append_unit(logic [UNIT_W-1:0] u);
		str_q.insert(str_q.size(), u);
	endfunction

	function automatic logic [UNIT_W-1:0] pick_hex();
		case ($urandom_range(0, 2))
			0: return DIG_0 + UNIT_W'($urandom_range(0, 9));
			1: return LOW_A + UNIT_W'($urandom_range(0, 5));
			default: return UP_A + UNIT_W'($urandom_range(0, 5));
		endcase
	endfunction

	function automatic logic [UNIT_W-1:0] pick_escape();
		case ($urandom_range(0, 6))
			0: return CH_N;
			1: return CH_T;
			2: return CH_QUOTE;
			3: return CH_BSL;
			4: return CH_SLASH;
			5: return CH_U;
			default: return UNIT_W'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	function automatic logic [UNIT_W-1:0] pick_unit();
		case ($urandom_range(0, 9))
			0, 1, 2: return UNIT_W'($urandom_range(0, 16'hFFFF));
			3: return pick_hex();
			4: return pick_escape();
			5: return CH_BSL;
			6: return CH_U;
			7: return UNIT_W'($urandom_range(16'h0020, 16'h007E));
			8: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
			default: begin
				// Characters just outside the hex digit ranges.
				case ($urandom_range(0, 5))
					0: return CH_SLASH;
					1: return 16'h003A;
					2: return 16'h0040;
					3: return 16'h0047;
					4: return 16'h0060;
					default: return 16'h0067;
				endcase
			end
		endcase
	endfunction

	task automatic build_string();
		int n_tok;
		int kind;
		n_tok = $urandom_range(1, 5);
		for (int t = 0; t < n_tok; t++) begin
			kind = $urandom_range(0, 9);
			if (kind <= 3)
				append_unit(pick_unit());
			else if (kind <= 5) begin
				append_unit(CH_BSL);
				append_unit(pick_escape());
			end else if (kind <= 7) begin
				append_unit(CH_BSL);
				append_unit(CH_U);
				repeat (4)
					append_unit(($urandom_range(0, 4) != 0) ? pick_hex() : pick_unit());
			end else if (kind == 8) begin
				// A unicode escape cut short by the end of the string.
				append_unit(CH_BSL);
				append_unit(CH_U);
				repeat ($urandom_range(0, 3))
					append_unit(($urandom_range(0, 2) != 0) ? pick_hex() : pick_unit());
				break;
			end else
				repeat ($urandom_range(1, 3))
					append_unit(UNIT_W'($urandom_range(0, 16'hFFFF)));
		end
	endtask

	task automatic send_word(logic [UNIT_W-1:0] u, logic eos);
		escaped_ch.valid <= 1'b1;
		escaped_ch.code_unit <= u;
		escaped_ch.end_of_string <= eos;
		do
			@(posedge clk);
		while (escaped_ch.ready !== 1'b1);
		sb.note_word(u, eos);
		words_sent++;
		if (tx_idle && $urandom_range(0, 3) == 0) begin
			escaped_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic send_string();
		for (int i = 0; i < str_q.size(); i++)
			send_word(str_q[i], i == str_q.size() - 1);
		str_q.delete();
	endtask

	task automatic wait_drained();
		escaped_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		escaped_ch.valid = 1'b0;
		escaped_ch.code_unit = '0;
		escaped_ch.end_of_string = 1'b0;
		arst_n = 1'b0;
		tx_idle = 1;
		rx_idle = 1;
		long_hold = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		str_q = '{16'h0000, CH_BSL, CH_N, CH_BSL, CH_T, CH_BSL, CH_QUOTE, CH_BSL, CH_BSL,
			CH_BSL, CH_SLASH, CH_BSL, 16'hFFFF};
		send_string();
		str_q = '{CH_BSL};
		send_string();
		str_q = '{CH_BSL, CH_U};
		send_string();
		str_q = '{CH_BSL, CH_U, DIG_9, LOW_F, UP_A, UP_F};
		send_string();
		str_q = '{CH_BSL, CH_U, CH_SLASH, 16'h003A, 16'h0067};
		send_string();
		str_q = '{CH_BSL, CH_U, CH_BSL, CH_U};
		send_string();
		str_q = '{CH_BSL, CH_U, LOW_A, CH_BSL, CH_N};
		send_string();

		while (words_sent < 160) begin
			tx_idle = $urandom_range(0, 3) != 0;
			rx_idle = $urandom_range(0, 3) != 0;
			build_string();
			send_string();
		end

		tx_idle = 0;
		long_hold = 1;
		while (long_hold) begin
			build_string();
			send_string();
		end
		wait_drained();

		while (words_sent < 300) begin
			tx_idle = $urandom_range(0, 3) != 0;
			rx_idle = $urandom_range(0, 3) != 0;
			build_string();
			send_string();
		end

		tx_idle = 0;
		rx_idle = 0;
		while (words_sent < 350) begin
			build_string();
			send_string();
		end
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		unescaped_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				unescaped_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold = 0;
				unescaped_ch.ready <= 1'b1;
			end else if (rx_idle && $urandom_range(0, 4) == 0) begin
				unescaped_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				unescaped_ch.ready <= 1'b1;
			end else
				unescaped_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && unescaped_ch.valid === 1'b1 && unescaped_ch.ready === 1'b1)
			sb.check_word(unescaped_ch.out_unit, unescaped_ch.unit_valid, unescaped_ch.last);
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> sim.f
rtl/jsu_pkg.sv
rtl/jsu_in_if.sv
rtl/jsu_out_if.sv
rtl/json_string_unescape_top.sv
tb/tb_top.sv
